>>> src/mcd_pkg.sv
// Shared types, constants and codes for the MIDI control-change to DAC encoder.
// Used by mcd_alu, mcd_seq and midi_cc_to_multiplexed_dac; depends on nothing.
`default_nettype none

package mcd_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int SEG_ID_COUNT   = 4;
    localparam int CFG_IW         = 3;
    localparam int CFG_DW         = 10;
    localparam int ACC_W          = 22;
    localparam int OPND_W         = 12;

    localparam logic [9:0] SEG_IDS [SEG_ID_COUNT] = '{10'd512, 10'd640, 10'd768, 10'd896};

    localparam logic [2:0] RST_FORCED_SLOT     = 3'd4;
    localparam logic [9:0] RST_SWITCH_INTERVAL = 10'd10;
    localparam logic [6:0] RST_SEGMENT_MAX     = 7'd103;
    localparam logic [9:0] RST_DAC_FLOOR       = 10'd126;
    localparam logic [9:0] RST_DAC_CEILING     = 10'd940;
    localparam logic [6:0] RST_AUDIO_FLOOR     = 7'd10;
    localparam logic [6:0] RST_AUDIO_CEILING   = 7'd117;

    typedef enum logic [CFG_IW-1:0] {
        REG_FORCED_SLOT     = 3'd0,
        REG_SWITCH_INTERVAL = 3'd1,
        REG_SEGMENT_MAX     = 3'd2,
        REG_DAC_FLOOR       = 3'd3,
        REG_DAC_CEILING     = 3'd4,
        REG_AUDIO_FLOOR     = 3'd5,
        REG_AUDIO_CEILING   = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_DIV127,
        ALU_DIV1023,
        ALU_CLAMP127,
        ALU_CLAMP1023
    } alu_op_t;

    typedef struct packed {
        alu_op_t                  op;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } alu_cmd_t;

    typedef struct packed {
        logic [2:0] forced_slot;
        logic [9:0] switch_interval;
        logic [6:0] segment_max;
        logic [9:0] dac_floor;
        logic [9:0] dac_ceiling;
        logic [6:0] audio_floor;
        logic [6:0] audio_ceiling;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_AUD_MUL,
        S_AUD_DIV,
        S_AUD_MAP,
        S_SEG_MUL,
        S_SEG_DIV,
        S_SEG_ADD,
        S_CODE_MUL,
        S_CODE_DIV,
        S_CODE_MAP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/midi_cc_to_multiplexed_dac.sv
// Top level of the MIDI control-change to multiplexed DAC encoder.
// Holds the configuration registers; instantiates mcd_seq and mcd_alu. Uses mcd_pkg.
//
// Input channel (in_valid/in_stall): one item is a control change (func 0) or a
// millisecond tick (func 1). Each accepted item yields exactly one result on the
// output channel (out_valid/out_stall) carrying the DAC code, the active slot and
// the PWM levels as they stand after the item.
// Ticks and most control changes run the slot and code steps only; a controller 0
// change on channel 1 runs the audio map first. All steps go through the one shared
// multiply/divide/clamp unit.
// in_stall is high while an item is in work; the next item waits until the result is loaded.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver still stalls when the following result is
// done, the sequencer holds until the output register frees up.
// Reset (rst_n low, asynchronous) clears all levels, the slot, the tick count and the
// output valid, and loads the configuration defaults. The user must write configuration
// via cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce this.
`default_nettype none

module midi_cc_to_multiplexed_dac #(
    parameter int SLOT_COUNT = mcd_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [mcd_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [mcd_pkg::CFG_DW-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [4:0]                  midi_channel,
    input  wire logic [6:0]                  controller,
    input  wire logic [6:0]                  cc_value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [9:0]                       dac_code,
    output logic [1:0]                       active_slot,
    output logic [9:0]                       audio_level,
    output logic [9:0]                       aux_one_level,
    output logic [9:0]                       aux_two_level,
    output logic [9:0]                       aux_three_level,
    output logic [7:0]                       led_level
);

    mcd_pkg::cfg_t                        cfg_reg;
    mcd_pkg::alu_cmd_t                    alu_cmd;
    logic signed [mcd_pkg::ACC_W-1:0]     alu_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forced_slot     <= mcd_pkg::RST_FORCED_SLOT;
            cfg_reg.switch_interval <= mcd_pkg::RST_SWITCH_INTERVAL;
            cfg_reg.segment_max     <= mcd_pkg::RST_SEGMENT_MAX;
            cfg_reg.dac_floor       <= mcd_pkg::RST_DAC_FLOOR;
            cfg_reg.dac_ceiling     <= mcd_pkg::RST_DAC_CEILING;
            cfg_reg.audio_floor     <= mcd_pkg::RST_AUDIO_FLOOR;
            cfg_reg.audio_ceiling   <= mcd_pkg::RST_AUDIO_CEILING;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcd_pkg::REG_FORCED_SLOT:     cfg_reg.forced_slot     <= cfg_data[2:0];
                mcd_pkg::REG_SWITCH_INTERVAL: cfg_reg.switch_interval <= cfg_data[9:0];
                mcd_pkg::REG_SEGMENT_MAX:     cfg_reg.segment_max     <= cfg_data[6:0];
                mcd_pkg::REG_DAC_FLOOR:       cfg_reg.dac_floor       <= cfg_data[9:0];
                mcd_pkg::REG_DAC_CEILING:     cfg_reg.dac_ceiling     <= cfg_data[9:0];
                mcd_pkg::REG_AUDIO_FLOOR:     cfg_reg.audio_floor     <= cfg_data[6:0];
                mcd_pkg::REG_AUDIO_CEILING:   cfg_reg.audio_ceiling   <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    mcd_seq #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .midi_channel    (midi_channel),
        .controller      (controller),
        .cc_value        (cc_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .dac_code        (dac_code),
        .active_slot     (active_slot),
        .audio_level     (audio_level),
        .aux_one_level   (aux_one_level),
        .aux_two_level   (aux_two_level),
        .aux_three_level (aux_three_level),
        .led_level       (led_level),
        .alu_cmd         (alu_cmd),
        .alu_acc         (alu_acc)
    );

    mcd_alu u_alu (
        .clk (clk),
        .cmd (alu_cmd),
        .acc (alu_acc)
    );

endmodule

`default_nettype wire

>>> src/mcd_alu.sv
// Shared arithmetic unit: multiply, divide by 127 or 1023, add and clamp.
// One accumulator register; commands come from mcd_seq. Depends on mcd_pkg.
`default_nettype none

module mcd_alu (
    input  wire logic                            clk,
    input  wire mcd_pkg::alu_cmd_t               cmd,
    output logic signed [mcd_pkg::ACC_W-1:0]     acc
);

    logic signed [mcd_pkg::ACC_W-1:0]   acc_reg;
    logic signed [mcd_pkg::ACC_W-1:0]   acc_next;
    logic signed [2*mcd_pkg::OPND_W-1:0] prod;
    logic                               neg;
    logic [mcd_pkg::ACC_W-2:0]          mag;
    logic [13:0]                        est7;
    logic [14:0]                        rem7;
    logic [13:0]                        q7;
    logic [10:0]                        est10;
    logic [11:0]                        rem10;
    logic [10:0]                        q10;
    logic signed [mcd_pkg::ACC_W-1:0]   qext7;
    logic signed [mcd_pkg::ACC_W-1:0]   qext10;
    logic signed [mcd_pkg::ACC_W:0]     sum;

    always_comb
    begin
        prod  = cmd.a * cmd.b;
        neg   = acc_reg[mcd_pkg::ACC_W-1];
        mag   = neg ? (mcd_pkg::ACC_W-1)'(-acc_reg) : (mcd_pkg::ACC_W-1)'(acc_reg);
        est7  = mag[20:7];
        rem7  = {8'd0, mag[6:0]} + {1'b0, est7};
        q7    = est7 + 14'(rem7 >= 15'd127);
        est10 = mag[20:10];
        rem10 = {2'd0, mag[9:0]} + {1'b0, est10};
        q10   = est10 + 11'(rem10 >= 12'd1023);
        qext7  = {8'd0, q7};
        qext10 = {11'd0, q10};
        sum   = {{(mcd_pkg::ACC_W+1-mcd_pkg::OPND_W){cmd.a[mcd_pkg::OPND_W-1]}}, cmd.a}
              + {acc_reg[mcd_pkg::ACC_W-1], acc_reg};
    end

    always_comb
    begin
        unique case (cmd.op)
            mcd_pkg::ALU_NOP:       acc_next = acc_reg;
            mcd_pkg::ALU_MUL:       acc_next = prod[mcd_pkg::ACC_W-1:0];
            mcd_pkg::ALU_DIV127:    acc_next = neg ? -qext7 : qext7;
            mcd_pkg::ALU_DIV1023:   acc_next = neg ? -qext10 : qext10;
            mcd_pkg::ALU_CLAMP127:
            begin
                priority if (sum < 0)
                    acc_next = '0;
                else if (sum > 23'sd127)
                    acc_next = 22'sd127;
                else
                    acc_next = sum[mcd_pkg::ACC_W-1:0];
            end
            mcd_pkg::ALU_CLAMP1023:
            begin
                priority if (sum < 0)
                    acc_next = '0;
                else if (sum > 23'sd1023)
                    acc_next = 22'sd1023;
                else
                    acc_next = sum[mcd_pkg::ACC_W-1:0];
            end
            default:                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

>>> src/mcd_seq.sv
// Sequencer, level and slot state, and output register of the encoder.
// Drives mcd_alu through alu_cmd_t; depends on mcd_pkg.
`default_nettype none

module mcd_seq #(
    parameter int SLOT_COUNT = mcd_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mcd_pkg::cfg_t                cfg,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         func,
    input  wire logic [4:0]                   midi_channel,
    input  wire logic [6:0]                   controller,
    input  wire logic [6:0]                   cc_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [9:0]                        dac_code,
    output logic [1:0]                        active_slot,
    output logic [9:0]                        audio_level,
    output logic [9:0]                        aux_one_level,
    output logic [9:0]                        aux_two_level,
    output logic [9:0]                        aux_three_level,
    output logic [7:0]                        led_level,
    output mcd_pkg::alu_cmd_t                 alu_cmd,
    input  wire logic signed [mcd_pkg::ACC_W-1:0] alu_acc
);

    localparam int SLOT_LIMIT = (SLOT_COUNT < mcd_pkg::SEG_ID_COUNT) ? SLOT_COUNT
                                                                    : mcd_pkg::SEG_ID_COUNT;

    mcd_pkg::state_t state_reg, state_next;

    logic       func_reg;
    logic [4:0] chan_reg;
    logic [6:0] ctl_reg;
    logic [6:0] val_reg;

    logic [6:0]  seg_level_reg [mcd_pkg::SEG_ID_COUNT];
    logic [7:0]  audio_byte_reg;
    logic [7:0]  aux_byte_reg [3];
    logic [7:0]  led_byte_reg;
    logic [1:0]  slot_reg;
    logic [10:0] elapsed_reg;

    logic        out_valid_reg;
    logic [9:0]  dac_code_reg;
    logic [1:0]  active_slot_reg;
    logic [9:0]  audio_level_reg;
    logic [9:0]  aux_one_reg;
    logic [9:0]  aux_two_reg;
    logic [9:0]  aux_three_reg;
    logic [7:0]  led_level_reg;

    logic        accept;
    logic        cc_ch1;
    logic        aud_item;
    logic [1:0]  cur_slot;
    logic [10:0] elapsed_inc;
    logic [2:0]  slot_inc;
    logic [7:0]  aud_diff;
    logic [10:0] dac_diff;
    logic        upd_en;
    logic        aud_wr;
    logic        out_ld;

    function automatic logic [7:0] doubled_byte(input logic [6:0] v);
        logic [7:0] b;
        b = {v, 1'b0};
        if (b > 8'd128)
            b = b + 8'd1;
        return b;
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != mcd_pkg::S_IDLE);
    assign cc_ch1   = !func_reg && (chan_reg == 5'd1);
    assign aud_item = cc_ch1 && (ctl_reg == 7'd0);
    assign cur_slot = (cfg.forced_slot < 3'd4) ? cfg.forced_slot[1:0] : slot_reg;
    assign elapsed_inc = (elapsed_reg < 11'd2047) ? elapsed_reg + 11'd1 : elapsed_reg;
    assign slot_inc = {1'b0, slot_reg} + 3'd1;
    assign aud_diff = {1'b0, cfg.audio_ceiling} - {1'b0, cfg.audio_floor};
    assign dac_diff = {1'b0, cfg.dac_ceiling} - {1'b0, cfg.dac_floor};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcd_pkg::S_IDLE:     if (accept) state_next = mcd_pkg::S_UPDATE;
            mcd_pkg::S_UPDATE:   state_next = aud_item ? mcd_pkg::S_AUD_MUL : mcd_pkg::S_SEG_MUL;
            mcd_pkg::S_AUD_MUL:  state_next = mcd_pkg::S_AUD_DIV;
            mcd_pkg::S_AUD_DIV:  state_next = mcd_pkg::S_AUD_MAP;
            mcd_pkg::S_AUD_MAP:  state_next = mcd_pkg::S_SEG_MUL;
            mcd_pkg::S_SEG_MUL:  state_next = mcd_pkg::S_SEG_DIV;
            mcd_pkg::S_SEG_DIV:  state_next = mcd_pkg::S_SEG_ADD;
            mcd_pkg::S_SEG_ADD:  state_next = mcd_pkg::S_CODE_MUL;
            mcd_pkg::S_CODE_MUL: state_next = mcd_pkg::S_CODE_DIV;
            mcd_pkg::S_CODE_DIV: state_next = mcd_pkg::S_CODE_MAP;
            mcd_pkg::S_CODE_MAP: state_next = mcd_pkg::S_DONE;
            mcd_pkg::S_DONE:     if (!out_valid_reg || !out_stall) state_next = mcd_pkg::S_IDLE;
            default:             state_next = mcd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        alu_cmd.op = mcd_pkg::ALU_NOP;
        alu_cmd.a  = '0;
        alu_cmd.b  = '0;
        upd_en     = 1'b0;
        aud_wr     = 1'b0;
        out_ld     = 1'b0;
        unique case (state_reg)
            mcd_pkg::S_UPDATE:   upd_en = 1'b1;
            mcd_pkg::S_AUD_MUL:
            begin
                alu_cmd.op = mcd_pkg::ALU_MUL;
                alu_cmd.a  = {5'd0, val_reg};
                alu_cmd.b  = {{4{aud_diff[7]}}, aud_diff};
            end
            mcd_pkg::S_AUD_DIV:  alu_cmd.op = mcd_pkg::ALU_DIV127;
            mcd_pkg::S_AUD_MAP:
            begin
                alu_cmd.op = mcd_pkg::ALU_CLAMP127;
                alu_cmd.a  = {5'd0, cfg.audio_floor};
            end
            mcd_pkg::S_SEG_MUL:
            begin
                aud_wr     = aud_item;
                alu_cmd.op = mcd_pkg::ALU_MUL;
                alu_cmd.a  = {5'd0, seg_level_reg[cur_slot]};
                alu_cmd.b  = {5'd0, cfg.segment_max};
            end
            mcd_pkg::S_SEG_DIV:  alu_cmd.op = mcd_pkg::ALU_DIV127;
            mcd_pkg::S_SEG_ADD:
            begin
                alu_cmd.op = mcd_pkg::ALU_CLAMP1023;
                alu_cmd.a  = {2'd0, mcd_pkg::SEG_IDS[cur_slot]};
            end
            mcd_pkg::S_CODE_MUL:
            begin
                alu_cmd.op = mcd_pkg::ALU_MUL;
                alu_cmd.a  = alu_acc[mcd_pkg::OPND_W-1:0];
                alu_cmd.b  = {dac_diff[10], dac_diff};
            end
            mcd_pkg::S_CODE_DIV: alu_cmd.op = mcd_pkg::ALU_DIV1023;
            mcd_pkg::S_CODE_MAP:
            begin
                alu_cmd.op = mcd_pkg::ALU_CLAMP1023;
                alu_cmd.a  = {2'd0, cfg.dac_floor};
            end
            mcd_pkg::S_DONE:     out_ld = !out_valid_reg || !out_stall;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mcd_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            chan_reg <= midi_channel;
            ctl_reg  <= controller;
            val_reg  <= cc_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcd_pkg::SEG_ID_COUNT; i++)
                seg_level_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                aux_byte_reg[i] <= '0;
            audio_byte_reg <= '0;
            led_byte_reg   <= '0;
            slot_reg       <= '0;
            elapsed_reg    <= '0;
        end
        else
        begin
            if (upd_en)
            begin
                if (func_reg)
                begin
                    if (elapsed_inc > {1'b0, cfg.switch_interval})
                    begin
                        slot_reg    <= (slot_inc >= 3'(SLOT_LIMIT)) ? 2'd0 : slot_inc[1:0];
                        elapsed_reg <= '0;
                    end
                    else
                    begin
                        elapsed_reg <= elapsed_inc;
                    end
                end
                else if (cc_ch1)
                begin
                    if (ctl_reg == 7'd0)
                        led_byte_reg <= {val_reg, 1'b0};
                    else if (ctl_reg >= 7'd2 && ctl_reg <= 7'd4)
                        aux_byte_reg[2'(ctl_reg - 7'd2)] <= doubled_byte(val_reg);
                    else if (ctl_reg >= 7'd30 && ctl_reg <= 7'd33)
                        seg_level_reg[2'(ctl_reg - 7'd30)] <= val_reg;
                end
            end
            if (aud_wr)
                audio_byte_reg <= doubled_byte(alu_acc[6:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ld)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            dac_code_reg    <= alu_acc[9:0];
            active_slot_reg <= cur_slot;
            audio_level_reg <= {audio_byte_reg, 2'b00};
            aux_one_reg     <= {aux_byte_reg[0], 2'b00};
            aux_two_reg     <= {aux_byte_reg[1], 2'b00};
            aux_three_reg   <= {aux_byte_reg[2], 2'b00};
            led_level_reg   <= led_byte_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign dac_code        = dac_code_reg;
    assign active_slot     = active_slot_reg;
    assign audio_level     = audio_level_reg;
    assign aux_one_level   = aux_one_reg;
    assign aux_two_level   = aux_two_reg;
    assign aux_three_level = aux_three_reg;
    assign led_level       = led_level_reg;

    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mcd_pkg::S_UPDATE))
        else $error("accepted item did not start the update step");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == mcd_pkg::S_DONE))
        else $error("result raised outside the done step");

    a_audio_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcd_pkg::S_AUD_MAP) |=> (alu_acc >= 0 && alu_acc <= 22'sd127))
        else $error("audio level left its range");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcd_pkg::S_DONE) |-> (alu_acc >= 0 && alu_acc <= 22'sd1023))
        else $error("dac code left its range");

endmodule

`default_nettype wire
